### rtl/sbrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbrq_pkg: shared types and constants of the spatial bucket request queue
// Field widths, operation and status codes, the neighbour probe offsets and
// the decoded request word passed from the sector decoder to the core.
// ----------------------------------------------------------------------------
package sbrq_pkg;

   // Transaction field widths
   localparam int REQ_OP_W   = 1;
   localparam int RESOURCE_W = 4;
   localparam int KIND_W     = 2;
   localparam int COORD_W    = 10;
   localparam int HANDLE_W   = 16;
   localparam int STATUS_W   = 3;

   // Operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_FIND = 1'b1;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED   = 3'd0,
      ST_INVALID = 3'd1,
      ST_FULL    = 3'd2,
      ST_FOUND   = 3'd3,
      ST_NONE    = 3'd4
   } status_type;

   // Neighbour search: centre, top, bottom, left, right, right-top,
   // right-bottom, left-bottom, left-top (two's complement offsets)
   localparam int NUM_PROBES = 9;
   localparam int PROBE_W    = 4;
   localparam logic [PROBE_W-1:0] LAST_PROBE = PROBE_W'(NUM_PROBES - 1);

   localparam logic [1:0] PROBE_DX [NUM_PROBES] =
      '{2'b00, 2'b00, 2'b00, 2'b11, 2'b01, 2'b01, 2'b01, 2'b11, 2'b11};
   localparam logic [1:0] PROBE_DY [NUM_PROBES] =
      '{2'b00, 2'b11, 2'b01, 2'b00, 2'b00, 2'b11, 2'b01, 2'b01, 2'b11};

   // Decoded request held for the whole transaction
   typedef struct packed {
      logic                op;
      logic                cls_ok;
      logic [COORD_W-1:0]  sx;
      logic [COORD_W-1:0]  sy;
      logic [HANDLE_W-1:0] handle;
   } dec_type;

endpackage
`default_nettype wire

### rtl/sbrq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbrq_if: request and response channels of the spatial bucket request queue
// Valid/ready channels; a transaction moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface sbrq_req_if;
   import sbrq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [REQ_OP_W-1:0]   req_op;
   logic [RESOURCE_W-1:0] resource;
   logic [KIND_W-1:0]     demand_kind;
   logic [COORD_W-1:0]    map_x;
   logic [COORD_W-1:0]    map_y;
   logic [HANDLE_W-1:0]   handle;

   modport source (
      output valid, req_op, resource, demand_kind, map_x, map_y, handle,
      input  ready
   );
   modport sink (
      input  valid, req_op, resource, demand_kind, map_x, map_y, handle,
      output ready
   );
endinterface

interface sbrq_rsp_if;
   import sbrq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] found_handle;

   modport source (
      output valid, status, found_handle,
      input  ready
   );
   modport sink (
      input  valid, status, found_handle,
      output ready
   );
endinterface
`default_nettype wire

### rtl/spatial_bucket_request_queue_core.sv
// From accept to response valid: an invalid class or an add off the grid goes from
//   S_PROBE to S_DONE; an add runs S_PROBE, S_CHECK, S_DONE; a find probes the sectors
//   in search order in S_PROBE, with S_CHECK for each on the grid, then S_POP on a hit.
// Throughput: one transaction at a time; the next is accepted in S_IDLE once the
//   result is loaded, so the serial bucket state probes set the find time.
// Reset: synchronous; a clearing pass then zeroes one bucket a cycle (1024 by default).
`default_nettype none
// ----------------------------------------------------------------------------
// spatial_bucket_request_queue_core: per-sector request FIFOs
// One FIFO of handles per resource, demand kind and grid sector, held in a
// bucket state memory (head, count) and an entry memory. An add appends to
// the bucket of its sector; a find pops from the first non-empty bucket of
// the searcher's sector and its eight neighbours.
// ----------------------------------------------------------------------------
module spatial_bucket_request_queue_core #(
   parameter int GRID_W       = 8,
   parameter int GRID_H       = 8,
   parameter int SECTOR_SIZE  = 16,
   parameter int NUM_RES      = 8,
   parameter int NUM_KINDS    = 2,
   parameter int BUCKET_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   sbrq_req_if.sink    req_if,
   sbrq_rsp_if.source  rsp_if
);
   import sbrq_pkg::*;

   localparam int NUM_BUCKETS = NUM_RES * NUM_KINDS * GRID_W * GRID_H;
   localparam int STORE_DEPTH = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int STORE_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SLOT_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int CNT_W   = $clog2(BUCKET_DEPTH + 1);
   localparam int META_W  = SLOT_W + CNT_W;
   localparam int IDX_W   = CNT_W + 1;
   localparam int STA_W   = STORE_W + 1;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_PROBE = 6'b000100,
      S_CHECK = 6'b001000,
      S_POP   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   // Memories
   logic [META_W-1:0]   bucket_meta_mem [NUM_BUCKETS];
   logic [HANDLE_W-1:0] entry_mem [STORE_DEPTH];

   // Control and payload registers
   state_type           state_ff, state_in;
   logic [BKT_W-1:0]    clr_ff, clr_in;
   logic [PROBE_W-1:0]  probe_ff, probe_in;
   logic [BKT_W-1:0]    bucket_ff, bucket_in;
   status_type          res_status_ff, res_status_in;
   logic [HANDLE_W-1:0] res_handle_ff, res_handle_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [META_W-1:0]   meta_rd_ff;
   logic [HANDLE_W-1:0] entry_rd_ff;

   // Datapath
   dec_type             dec;
   logic [BKT_W-1:0]    cls_base;
   logic                probe_on_grid;
   logic [BKT_W-1:0]    probe_bucket;
   logic                req_accept;
   logic [SLOT_W-1:0]   meta_head;
   logic [CNT_W-1:0]    meta_count;
   logic [SLOT_W-1:0]   head_next;
   logic [IDX_W-1:0]    slot_sum;
   logic [SLOT_W-1:0]   add_slot;
   logic [SLOT_W-1:0]   slot_sel;
   logic [STA_W-1:0]    entry_sum;
   logic [STORE_W-1:0]  entry_addr;
   logic                meta_we;
   logic                meta_re;
   logic [BKT_W-1:0]    meta_waddr;
   logic [META_W-1:0]   meta_wdata;
   logic                entry_we;
   logic                entry_re;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.found_handle = rsp_handle_ff;

   sbrq_sector_decode #(
      .NUM_RES     (NUM_RES),
      .NUM_KINDS   (NUM_KINDS),
      .GRID_W      (GRID_W),
      .GRID_H      (GRID_H),
      .SECTOR_SIZE (SECTOR_SIZE),
      .BKT_W       (BKT_W)
   ) u_decode (
      .clock       (clock),
      .load        (req_accept),
      .req_op      (req_if.req_op),
      .resource    (req_if.resource),
      .demand_kind (req_if.demand_kind),
      .map_x       (req_if.map_x),
      .map_y       (req_if.map_y),
      .handle      (req_if.handle),
      .dec_ff      (dec),
      .cls_base_ff (cls_base)
   );

   sbrq_probe_gen #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H),
      .BKT_W  (BKT_W)
   ) u_probe (
      .sx        (dec.sx),
      .sy        (dec.sy),
      .probe_idx (probe_ff),
      .cls_base  (cls_base),
      .on_grid   (probe_on_grid),
      .bucket    (probe_bucket)
   );

   // Bucket state fields and FIFO slot arithmetic
   always_comb begin
      meta_head  = meta_rd_ff[META_W-1:CNT_W];
      meta_count = meta_rd_ff[CNT_W-1:0];
      head_next  = (meta_head == SLOT_W'(BUCKET_DEPTH - 1)) ? '0 : meta_head + 1'b1;
      // head and count both below the depth when not full: one subtract wraps
      slot_sum   = IDX_W'(meta_head) + IDX_W'(meta_count);
      add_slot   = (slot_sum >= IDX_W'(BUCKET_DEPTH)) ?
                   SLOT_W'(slot_sum - IDX_W'(BUCKET_DEPTH)) : SLOT_W'(slot_sum);
      slot_sel   = (dec.op == OP_ADD) ? add_slot : meta_head;
      entry_sum  = STA_W'(bucket_ff) * STA_W'(BUCKET_DEPTH) + STA_W'(slot_sel);
      entry_addr = entry_sum[STORE_W-1:0];
   end

   // Sequencer: one transaction at a time, so a bucket's write-back always
   // lands before the next read of the bucket state
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      probe_in      = probe_ff;
      bucket_in     = bucket_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      meta_we       = 1'b0;
      meta_re       = 1'b0;
      meta_waddr    = bucket_ff;
      meta_wdata    = '0;
      entry_we      = 1'b0;
      entry_re      = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == BKT_W'(NUM_BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               probe_in      = '0;
               res_handle_in = '0;
               state_in      = S_PROBE;
            end
         end
         S_PROBE: begin
            if (!dec.cls_ok) begin
               res_status_in = ST_INVALID;
               state_in      = S_DONE;
            end else if (probe_on_grid) begin
               meta_re   = 1'b1;
               bucket_in = probe_bucket;
               state_in  = S_CHECK;
            end else if (dec.op == OP_ADD) begin
               res_status_in = ST_INVALID;
               state_in      = S_DONE;
            end else if (probe_ff == LAST_PROBE) begin
               res_status_in = ST_NONE;
               state_in      = S_DONE;
            end else begin
               probe_in = probe_ff + 1'b1;
            end
         end
         S_CHECK: begin
            if (dec.op == OP_ADD) begin
               if (meta_count == CNT_W'(BUCKET_DEPTH)) begin
                  res_status_in = ST_FULL;
               end else begin
                  entry_we      = 1'b1;
                  meta_we       = 1'b1;
                  meta_wdata    = {meta_head, meta_count + 1'b1};
                  res_status_in = ST_ADDED;
               end
               state_in = S_DONE;
            end else if (meta_count == '0) begin
               if (probe_ff == LAST_PROBE) begin
                  res_status_in = ST_NONE;
                  state_in      = S_DONE;
               end else begin
                  probe_in = probe_ff + 1'b1;
                  state_in = S_PROBE;
               end
            end else begin
               entry_re   = 1'b1;
               meta_we    = 1'b1;
               meta_wdata = {head_next, meta_count - 1'b1};
               state_in   = S_POP;
            end
         end
         S_POP: begin
            res_handle_in = entry_rd_ff;
            res_status_in = ST_FOUND;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_handle_in = res_handle_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         probe_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bucket_ff     <= bucket_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   // Bucket state memory: head and count per bucket
   always_ff @(posedge clock) begin
      if (meta_we) begin
         bucket_meta_mem[meta_waddr] <= meta_wdata;
      end
      if (meta_re) begin
         meta_rd_ff <= bucket_meta_mem[probe_bucket];
      end
   end

   // Entry memory: BUCKET_DEPTH handle slots per bucket
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_addr] <= dec.handle;
      end
      if (entry_re) begin
         entry_rd_ff <= entry_mem[entry_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/sbrq_sector_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbrq_sector_decode: request decode stage
// Registers the sector column and row (map position divided by the sector
// size through a reciprocal multiply), the class check and the bucket base
// of the resource and demand kind.
// ----------------------------------------------------------------------------
module sbrq_sector_decode #(
   parameter int NUM_RES     = 8,
   parameter int NUM_KINDS   = 2,
   parameter int GRID_W      = 8,
   parameter int GRID_H      = 8,
   parameter int SECTOR_SIZE = 16,
   parameter int BKT_W       = 10
) (
   input  logic                            clock,
   input  logic                            load,
   input  logic [sbrq_pkg::REQ_OP_W-1:0]   req_op,
   input  logic [sbrq_pkg::RESOURCE_W-1:0] resource,
   input  logic [sbrq_pkg::KIND_W-1:0]     demand_kind,
   input  logic [sbrq_pkg::COORD_W-1:0]    map_x,
   input  logic [sbrq_pkg::COORD_W-1:0]    map_y,
   input  logic [sbrq_pkg::HANDLE_W-1:0]   handle,
   output sbrq_pkg::dec_type               dec_ff,
   output logic [BKT_W-1:0]                cls_base_ff
);
   import sbrq_pkg::*;

   // Exact floor division of a COORD_W-bit value: multiply by
   // ceil(2^(COORD_W+l) / SECTOR_SIZE), l = ceil(log2 SECTOR_SIZE), and shift
   localparam int SEC_SHIFT   = COORD_W + $clog2(SECTOR_SIZE);
   localparam int SEC_MULT    = ((1 << SEC_SHIFT) + SECTOR_SIZE - 1) / SECTOR_SIZE;
   localparam int MUL_W       = 2 * COORD_W + 1;
   localparam int NUM_SECTORS = GRID_W * GRID_H;
   localparam int SUM_W       = BKT_W + 1;
   localparam int RES_CMP_W   = RESOURCE_W + 2;
   localparam int KIND_CMP_W  = KIND_W + 2;

   logic [MUL_W-1:0] prod_x;
   logic [MUL_W-1:0] prod_y;
   logic [SUM_W-1:0] cls_idx;
   logic [SUM_W-1:0] cls_base_sum;
   dec_type          dec_in;
   logic [BKT_W-1:0] cls_base_in;

   // Divide, check the class and form the class base
   always_comb begin
      prod_x = MUL_W'(map_x) * MUL_W'(SEC_MULT);
      prod_y = MUL_W'(map_y) * MUL_W'(SEC_MULT);

      dec_in.op     = req_op[0];
      dec_in.cls_ok = ({2'b00, resource} < RES_CMP_W'(NUM_RES)) &&
                      ({2'b00, demand_kind} < KIND_CMP_W'(NUM_KINDS));
      dec_in.sx     = COORD_W'(prod_x >> SEC_SHIFT);
      dec_in.sy     = COORD_W'(prod_y >> SEC_SHIFT);
      dec_in.handle = handle;

      // Only meaningful for a valid class, where it stays below the bucket count
      cls_idx      = SUM_W'(resource) * SUM_W'(NUM_KINDS) + SUM_W'(demand_kind);
      cls_base_sum = cls_idx * SUM_W'(NUM_SECTORS);
      cls_base_in  = cls_base_sum[BKT_W-1:0];
   end

   // Hold the decoded transaction
   always_ff @(posedge clock) begin
      if (load) begin
         dec_ff      <= dec_in;
         cls_base_ff <= cls_base_in;
      end
   end

endmodule
`default_nettype wire

### rtl/sbrq_probe_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbrq_probe_gen: neighbour probe address generator
// Applies the offset of the current probe to the sector, flags sectors off
// the grid and forms the bucket index of the probed sector.
// ----------------------------------------------------------------------------
module sbrq_probe_gen #(
   parameter int GRID_W = 8,
   parameter int GRID_H = 8,
   parameter int BKT_W  = 10
) (
   input  logic [sbrq_pkg::COORD_W-1:0] sx,
   input  logic [sbrq_pkg::COORD_W-1:0] sy,
   input  logic [sbrq_pkg::PROBE_W-1:0] probe_idx,
   input  logic [BKT_W-1:0]             cls_base,
   output logic                         on_grid,
   output logic [BKT_W-1:0]             bucket
);
   import sbrq_pkg::*;

   localparam int POS_W = COORD_W + 2;
   localparam int SUM_W = BKT_W + 1;

   logic [1:0]       dx;
   logic [1:0]       dy;
   logic [POS_W-1:0] px;
   logic [POS_W-1:0] py;
   logic [SUM_W-1:0] sum;

   // Offset the sector; a negative position shows in the top bit
   always_comb begin
      dx = PROBE_DX[probe_idx];
      dy = PROBE_DY[probe_idx];
      px = {2'b00, sx} + {{COORD_W{dx[1]}}, dx};
      py = {2'b00, sy} + {{COORD_W{dy[1]}}, dy};

      on_grid = !px[POS_W-1] && (px < POS_W'(GRID_W)) &&
                !py[POS_W-1] && (py < POS_W'(GRID_H));

      sum    = SUM_W'(cls_base) + SUM_W'(px[COORD_W-1:0]) * SUM_W'(GRID_H) +
               SUM_W'(py[COORD_W-1:0]);
      bucket = sum[BKT_W-1:0];
   end

endmodule
`default_nettype wire

### rtl/sbrq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbrq_checker: port-level checks of the spatial bucket request queue
// Watches the request and response channels; bound to the core below.
// ----------------------------------------------------------------------------
module sbrq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [sbrq_pkg::STATUS_W-1:0] rsp_status,
   input logic [sbrq_pkg::HANDLE_W-1:0] rsp_found_handle
);
   import sbrq_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Keep a stalled response payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_found_handle))
      else $error("response payload changed while stalled");

   // Only a successful find carries a handle
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_FOUND) |-> (rsp_found_handle == '0))
      else $error("handle returned without a find hit");

   // Status codes stay within the defined set
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_ADDED || rsp_status == ST_INVALID ||
                     rsp_status == ST_FULL || rsp_status == ST_FOUND ||
                     rsp_status == ST_NONE))
      else $error("undefined response status");

   // No transaction is taken or offered right after reset (clearing pass)
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("channel active straight after reset");

endmodule

bind spatial_bucket_request_queue_core sbrq_checker u_sbrq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_found_handle (rsp_if.found_handle)
);
`default_nettype wire

### bench/sbrq_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbrq_scoreboard: result checker of the spatial bucket request queue
// Watches both channels and plays every accepted request against its own
// per-sector bucket queues. It predicts each status and taken handle, then
// compares every accepted response, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module sbrq_scoreboard #(
   parameter int GRID_W       = 8,
   parameter int GRID_H       = 8,
   parameter int SECTOR_SIZE  = 16,
   parameter int NUM_RES      = 8,
   parameter int NUM_KINDS    = 2,
   parameter int BUCKET_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   sbrq_req_if  req_mon,
   sbrq_rsp_if  rsp_mon,
   output int   mismatches,
   output int   outstanding
);
   import sbrq_pkg::*;

   localparam int NUM_BUCKETS = NUM_RES * NUM_KINDS * GRID_W * GRID_H;
   localparam int PEND_DEPTH  = 16;

   // Search order: centre, top, bottom, left, right, then the four corners
   localparam int STEP_X [9] = '{0, 0, 0, -1, 1, 1, 1, -1, -1};
   localparam int STEP_Y [9] = '{0, -1, 1, 0, 0, -1, 1, 1, -1};

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
   } outcome_type;

   logic [HANDLE_W-1:0] handle_slots [NUM_BUCKETS*BUCKET_DEPTH];
   int                  bucket_oldest [NUM_BUCKETS];
   int                  bucket_fill [NUM_BUCKETS];
   outcome_type         awaited [PEND_DEPTH];
   int                  pend_rd;
   int                  pend_wr;
   int                  pend_count = 0;
   outcome_type         due;

   function automatic int bucket_index(input int res, input int kind,
                                       input int sx, input int sy);
      return ((res * NUM_KINDS + kind) * GRID_W + sx) * GRID_H + sy;
   endfunction

   // File an add into its bucket or take the oldest handle near the searcher
   function automatic outcome_type serve_request(
      input logic [REQ_OP_W-1:0]   op,
      input logic [RESOURCE_W-1:0] res,
      input logic [KIND_W-1:0]     kind,
      input logic [COORD_W-1:0]    mx,
      input logic [COORD_W-1:0]    my,
      input logic [HANDLE_W-1:0]   h
   );
      outcome_type r;
      int          sx, sy, px, py, b, slot;
      bit          taken;
      r.status = ST_NONE;
      r.handle = '0;
      sx       = int'(mx) / SECTOR_SIZE;
      sy       = int'(my) / SECTOR_SIZE;
      taken    = 1'b0;
      if (int'(res) >= NUM_RES || int'(kind) >= NUM_KINDS) begin
         r.status = ST_INVALID;
      end else if (op == OP_ADD) begin
         if (sx >= GRID_W || sy >= GRID_H) begin
            r.status = ST_INVALID;
         end else begin
            b = bucket_index(res, kind, sx, sy);
            if (bucket_fill[b] >= BUCKET_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               slot = (bucket_oldest[b] + bucket_fill[b]) % BUCKET_DEPTH;
               handle_slots[b*BUCKET_DEPTH + slot] = h;
               bucket_fill[b]++;
               r.status = ST_ADDED;
            end
         end
      end else begin
         for (int k = 0; k < 9; k++) begin
            px = sx + STEP_X[k];
            py = sy + STEP_Y[k];
            if (!taken && px >= 0 && px < GRID_W && py >= 0 && py < GRID_H) begin
               b = bucket_index(res, kind, px, py);
               if (bucket_fill[b] != 0) begin
                  r.handle         = handle_slots[b*BUCKET_DEPTH + bucket_oldest[b]];
                  r.status         = ST_FOUND;
                  bucket_oldest[b] = (bucket_oldest[b] + 1) % BUCKET_DEPTH;
                  bucket_fill[b]--;
                  taken            = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   // Compare the response first, then predict the newly accepted request
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            bucket_oldest[i] = 0;
            bucket_fill[i]   = 0;
         end
         pend_rd    = 0;
         pend_wr    = 0;
         pend_count = 0;
         mismatches = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pend_count == 0) begin
               mismatches++;
               $display("%0t: response with nothing outstanding: status %0d handle %h",
                        $time, rsp_mon.status, rsp_mon.found_handle);
            end else begin
               due        = awaited[pend_rd];
               pend_rd    = (pend_rd + 1) % PEND_DEPTH;
               pend_count = pend_count - 1;
               if (rsp_mon.status !== due.status ||
                   rsp_mon.found_handle !== due.handle) begin
                  mismatches++;
                  $display("%0t: expected status %0d handle %h, got status %0d handle %h",
                           $time, due.status, due.handle,
                           rsp_mon.status, rsp_mon.found_handle);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (pend_count == PEND_DEPTH) begin
               mismatches++;
               $display("%0t: expected at most %0d transactions in flight, got %0d",
                        $time, PEND_DEPTH, PEND_DEPTH + 1);
            end else begin
               awaited[pend_wr] = serve_request(req_mon.req_op, req_mon.resource,
                                                req_mon.demand_kind, req_mon.map_x,
                                                req_mon.map_y, req_mon.handle);
               pend_wr          = (pend_wr + 1) % PEND_DEPTH;
               pend_count       = pend_count + 1;
            end
         end
      end
      outstanding = pend_count;
   end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the spatial bucket request queue
// Drives add and find transactions, first a directed sweep of the edge cases
// and then random traffic clustered around moving hot spots so that buckets
// fill, overflow and drain through every neighbour. The sender runs in
// bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;
   import sbrq_pkg::*;

   localparam int GRID_W       = 8;
   localparam int GRID_H       = 8;
   localparam int SECTOR_SIZE  = 16;
   localparam int NUM_RES      = 8;
   localparam int NUM_KINDS    = 2;
   localparam int BUCKET_DEPTH = 4;
   localparam int RANDOM_ITEMS = 1400;
   localparam int IDLE_LIMIT   = 4000;

   localparam int AROUND_X [9] = '{0, 0, 0, -1, 1, 1, 1, -1, -1};
   localparam int AROUND_Y [9] = '{0, -1, 1, 0, 0, -1, 1, 1, -1};

   typedef struct packed {
      logic [REQ_OP_W-1:0]   op;
      logic [RESOURCE_W-1:0] res;
      logic [KIND_W-1:0]     kind;
      logic [COORD_W-1:0]    mx;
      logic [COORD_W-1:0]    my;
      logic [HANDLE_W-1:0]   h;
   } req_item_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_CHOKE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   int          mismatches;
   int          outstanding;
   int          idle_cycles = 0;
   int          burst_left  = 0;
   int          hot_res, hot_kind, hot_sx, hot_sy;
   rx_mode_type rx_mode     = RX_OPEN;
   int          rx_left     = 0;
   int          rx_phase    = 0;

   sbrq_req_if req_ch ();
   sbrq_rsp_if rsp_ch ();

   spatial_bucket_request_queue_core #(
      .GRID_W      (GRID_W),
      .GRID_H      (GRID_H),
      .SECTOR_SIZE (SECTOR_SIZE),
      .NUM_RES     (NUM_RES),
      .NUM_KINDS   (NUM_KINDS),
      .BUCKET_DEPTH(BUCKET_DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   sbrq_scoreboard #(
      .GRID_W      (GRID_W),
      .GRID_H      (GRID_H),
      .SECTOR_SIZE (SECTOR_SIZE),
      .NUM_RES     (NUM_RES),
      .NUM_KINDS   (NUM_KINDS),
      .BUCKET_DEPTH(BUCKET_DEPTH)
   ) checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: switch to a random stall pattern at the end of each random-length run
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 200);
      end else begin
         rx_left--;
      end
      rx_phase++;
      case (rx_mode)
         RX_OPEN:  rsp_ch.ready = 1'b1;
         RX_COIN:  rsp_ch.ready = 1'($urandom_range(0, 1));
         RX_COMB:  rsp_ch.ready = (rx_phase % 5) > 1;
         default:  rsp_ch.ready = ($urandom_range(0, 7) == 0);
      endcase
   end

   // Watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_item_type make_item(input int op, input int res, input int kind,
                                              input int mx, input int my, input int h);
      req_item_type it;
      it.op   = REQ_OP_W'(op);
      it.res  = RESOURCE_W'(res);
      it.kind = KIND_W'(kind);
      it.mx   = COORD_W'(mx);
      it.my   = COORD_W'(my);
      it.h    = HANDLE_W'(h);
      return it;
   endfunction

   // Random transaction, mostly around the current hot spot
   function automatic req_item_type roll_item();
      req_item_type it;
      int           pick, sx, sy, far_edge;
      pick     = $urandom_range(0, 99);
      sx       = hot_sx;
      sy       = hot_sy;
      far_edge = $urandom_range(0, 1) ? $urandom_range(GRID_W*SECTOR_SIZE,
                                                       GRID_W*SECTOR_SIZE + SECTOR_SIZE - 1)
                                      : $urandom_range(GRID_W*SECTOR_SIZE, 1023);
      if ($urandom_range(0, 1)) sx = sx + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1)) sy = sy + $urandom_range(0, 2) - 1;
      if (sx < 0) sx = 0;
      if (sx >= GRID_W) sx = GRID_W - 1;
      if (sy < 0) sy = 0;
      if (sy >= GRID_H) sy = GRID_H - 1;
      it = make_item((pick < 60) ? OP_ADD : OP_FIND, hot_res, hot_kind,
                     sx*SECTOR_SIZE + $urandom_range(0, SECTOR_SIZE-1),
                     sy*SECTOR_SIZE + $urandom_range(0, SECTOR_SIZE-1),
                     $urandom_range(0, 65535));
      if (pick < 8) begin
         // noise across the whole field range
         it = make_item($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 3),
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 65535));
      end else if (pick < 14) begin
         // bad resource or kind code
         it.op = REQ_OP_W'($urandom_range(0, 1));
         if ($urandom_range(0, 1)) it.res  = RESOURCE_W'($urandom_range(NUM_RES, 15));
         else                      it.kind = KIND_W'($urandom_range(NUM_KINDS, 3));
      end else if (pick < 20) begin
         // past the grid edge on one or both axes
         it.op = REQ_OP_W'($urandom_range(0, 1));
         case ($urandom_range(0, 2))
            0:       it.mx = COORD_W'(far_edge);
            1:       it.my = COORD_W'(far_edge);
            default: begin
               it.mx = COORD_W'(far_edge);
               it.my = COORD_W'($urandom_range(GRID_H*SECTOR_SIZE, 1023));
            end
         endcase
      end
      return it;
   endfunction

   // Present one transaction, hold it until taken, then pace the bursts
   task automatic offer(input req_item_type it);
      int gap;
      req_ch.valid       = 1'b1;
      req_ch.req_op      = it.op;
      req_ch.resource    = it.res;
      req_ch.demand_kind = it.kind;
      req_ch.map_x       = it.mx;
      req_ch.map_y       = it.my;
      req_ch.handle      = it.h;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   initial begin
      reset              = 1'b1;
      rsp_ch.ready       = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.req_op      = '0;
      req_ch.resource    = '0;
      req_ch.demand_kind = '0;
      req_ch.map_x       = '0;
      req_ch.map_y       = '0;
      req_ch.handle      = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // nothing stored yet: a find comes back empty
      offer(make_item(OP_FIND, 0, 0, 0, 0, 16'hFFFF));
      // no-resource and no-kind codes, and an add off the grid
      offer(make_item(OP_ADD, NUM_RES, 0, 5, 5, 16'h1234));
      offer(make_item(OP_FIND, 0, NUM_KINDS, 5, 5, 0));
      offer(make_item(OP_ADD, 1, 1, 1023, 1023, 16'hAAAA));
      // fill the nine sectors around (3,3) in reverse, then drain in search order
      for (int k = 8; k >= 0; k--) begin
         offer(make_item(OP_ADD, 2, 0, (3 + AROUND_X[k])*SECTOR_SIZE + k,
                         (3 + AROUND_Y[k])*SECTOR_SIZE + 15 - k, 16'h0100 + k));
      end
      for (int k = 0; k < 9; k++) begin
         offer(make_item(OP_FIND, 2, 0, 3*SECTOR_SIZE + 7, 3*SECTOR_SIZE + 7, k));
      end
      // far corner bucket: fill to depth, then one more overflows
      offer(make_item(OP_ADD, NUM_RES-1, NUM_KINDS-1, 127, 127, 16'hFFFF));
      offer(make_item(OP_ADD, NUM_RES-1, NUM_KINDS-1, 112, 112, 16'h0000));
      offer(make_item(OP_ADD, NUM_RES-1, NUM_KINDS-1, 120, 113, 16'h5A5A));
      offer(make_item(OP_ADD, NUM_RES-1, NUM_KINDS-1, 113, 126, 16'hA5A5));
      offer(make_item(OP_ADD, NUM_RES-1, NUM_KINDS-1, 127, 112, 16'h1111));
      // searcher just past the right edge still reaches the corner bucket
      offer(make_item(OP_FIND, NUM_RES-1, NUM_KINDS-1, 128, 120, 0));

      // random traffic around a hot spot that moves every few dozen items
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            hot_res  = $urandom_range(0, NUM_RES-1);
            hot_kind = $urandom_range(0, NUM_KINDS-1);
            hot_sx   = $urandom_range(0, GRID_W-1);
            hot_sy   = $urandom_range(0, GRID_H-1);
         end
         offer(roll_item());
      end
      req_ch.valid = 1'b0;

      // drain, then give the block time to show any stray response
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### spatial_bucket_request_queue_core.f
rtl/sbrq_pkg.sv
rtl/sbrq_if.sv
rtl/sbrq_sector_decode.sv
rtl/sbrq_probe_gen.sv
rtl/spatial_bucket_request_queue_core.sv
rtl/sbrq_checker.sv
bench/sbrq_scoreboard.sv
bench/tb.sv
